FILE: sv/sbfs_pkg.sv
// Package: widths, register indexes and shared types of the fraud scorer.
package sbfs_pkg;
	localparam int FRAC_BITS   = 16;
	localparam int AMOUNT_BITS = 24;
	localparam int PROB_W      = FRAC_BITS + 1;
	localparam int LOSS_W      = FRAC_BITS + 7;
	localparam int NUM_W       = 2 * PROB_W;
	localparam int DEN_W       = NUM_W + 1;
	localparam int Q_W         = FRAC_BITS + 1;
	localparam int NUM_CELLS   = FRAC_BITS + 1;
	localparam int CFG_W       = 24;
	localparam int IDX_W       = 3;
	localparam logic [PROB_W-1:0] ONE_Q = PROB_W'(1) << FRAC_BITS;

	localparam logic [IDX_W-1:0] REG_PRIOR     = 3'd0;
	localparam logic [IDX_W-1:0] REG_THRESH    = 3'd1;
	localparam logic [IDX_W-1:0] REG_AMT_F     = 3'd2;
	localparam logic [IDX_W-1:0] REG_AMT_L     = 3'd3;
	localparam logic [IDX_W-1:0] REG_LOC_F     = 3'd4;
	localparam logic [IDX_W-1:0] REG_LOC_L     = 3'd5;
	localparam logic [IDX_W-1:0] REG_DEV_F     = 3'd6;
	localparam logic [IDX_W-1:0] REG_DEV_L     = 3'd7;

	localparam logic [1:0] ACT_APPROVE = 2'd0;
	localparam logic [1:0] ACT_DECLINE = 2'd1;
	localparam logic [1:0] ACT_REVIEW  = 2'd2;

	// Item state carried down the chain beside the division.
	typedef struct packed {
		logic loc;
		logic dev;
		logic err;
	} side_t;

	// One division stage: partial remainder, quotient so far, divisor.
	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [Q_W-1:0]   quo;
		logic [DEN_W-1:0] den;
	} div_t;

	function automatic logic [PROB_W-1:0] sat_prob(input logic [PROB_W-1:0] v);
		return (v > ONE_Q) ? ONE_Q : v;
	endfunction
endpackage

FILE: sv/sequential_bayes_fraud_scorer_unit.sv
// Top level: configuration, three chained Bayes updates and loss decision.
// Each update registers its likelihood products, then runs its division cells; an output register follows.
// Throughput: one item per cycle when not stalled; the whole chain advances on one enable.
// The chain stalls only while the output register holds an untaken beat.
// Reset (arst_n low) clears all valid bits and loads the register defaults.
// No clearing pass; the block accepts items as soon as reset is released.
module sequential_bayes_fraud_scorer_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [sbfs_pkg::AMOUNT_BITS-1:0] amount,
	input  logic                             unusual_location,
	input  logic                             unusual_device,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [sbfs_pkg::PROB_W-1:0]      posterior_fraud,
	output logic [1:0]                       action,
	output logic [sbfs_pkg::LOSS_W-1:0]      expected_loss,
	output logic                             error,
	input  logic                             cfg_we,
	input  logic [sbfs_pkg::IDX_W-1:0]       cfg_index,
	input  logic [sbfs_pkg::CFG_W-1:0]       cfg_data
);
	localparam int PW = sbfs_pkg::PROB_W;
	localparam int LW = sbfs_pkg::LOSS_W;

	logic [PW-1:0] prior_q, amt_f_q, amt_l_q, loc_f_q, loc_l_q, dev_f_q, dev_l_q;
	logic [sbfs_pkg::AMOUNT_BITS-1:0] thresh_q;
	logic en;

	// Write configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_q  <= PW'(1311);
			thresh_q <= sbfs_pkg::AMOUNT_BITS'(5000);
			amt_f_q  <= PW'(45875);
			amt_l_q  <= PW'(6554);
			loc_f_q  <= PW'(52429);
			loc_l_q  <= PW'(3277);
			dev_f_q  <= PW'(49152);
			dev_l_q  <= PW'(5243);
		end else if (cfg_we) begin
			unique case (cfg_index)
				sbfs_pkg::REG_PRIOR:  prior_q  <= cfg_data[PW-1:0];
				sbfs_pkg::REG_THRESH: thresh_q <= cfg_data[sbfs_pkg::AMOUNT_BITS-1:0];
				sbfs_pkg::REG_AMT_F:  amt_f_q  <= cfg_data[PW-1:0];
				sbfs_pkg::REG_AMT_L:  amt_l_q  <= cfg_data[PW-1:0];
				sbfs_pkg::REG_LOC_F:  loc_f_q  <= cfg_data[PW-1:0];
				sbfs_pkg::REG_LOC_L:  loc_l_q  <= cfg_data[PW-1:0];
				sbfs_pkg::REG_DEV_F:  dev_f_q  <= cfg_data[PW-1:0];
				sbfs_pkg::REG_DEV_L:  dev_l_q  <= cfg_data[PW-1:0];
				default: ;
			endcase
		end
	end

	// Advance the chain whenever the output register is free or being taken.
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	logic v1, v2, v3;
	logic [PW-1:0] p1, p2, p3;
	sbfs_pkg::side_t s0, s1, s2, s3;

	assign s0 = '{loc: unusual_location, dev: unusual_device, err: 1'b0};

	sbfs_update u_amt (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(in_valid && en), .in_p(sbfs_pkg::sat_prob(prior_q)),
		.flag(amount >= thresh_q),
		.pf(sbfs_pkg::sat_prob(amt_f_q)), .pl(sbfs_pkg::sat_prob(amt_l_q)),
		.in_side(s0), .out_valid(v1), .out_p(p1), .out_side(s1)
	);
	sbfs_update u_loc (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v1), .in_p(p1), .flag(s1.loc),
		.pf(sbfs_pkg::sat_prob(loc_f_q)), .pl(sbfs_pkg::sat_prob(loc_l_q)),
		.in_side(s1), .out_valid(v2), .out_p(p2), .out_side(s2)
	);
	sbfs_update u_dev (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v2), .in_p(p2), .flag(s2.dev),
		.pf(sbfs_pkg::sat_prob(dev_f_q)), .pl(sbfs_pkg::sat_prob(dev_l_q)),
		.in_side(s2), .out_valid(v3), .out_p(p3), .out_side(s3)
	);

	// Least expected loss wins; ties keep the earlier action; an error forces approve at zero loss.
	logic [PW-1:0] legit;
	logic [LW-1:0] l_app, l_dec, l_rev, best;
	logic [1:0]    act;
	always_comb begin
		legit = sbfs_pkg::ONE_Q - p3;
		l_app = LW'(p3) * LW'(100);
		l_dec = LW'(legit) * LW'(20);
		l_rev = LW'(p3) * LW'(10) + LW'(legit) * LW'(2);
		act   = sbfs_pkg::ACT_APPROVE;
		best  = l_app;
		if (l_dec < best) begin
			act  = sbfs_pkg::ACT_DECLINE;
			best = l_dec;
		end
		if (l_rev < best) begin
			act  = sbfs_pkg::ACT_REVIEW;
			best = l_rev;
		end
		if (s3.err) begin
			act  = sbfs_pkg::ACT_APPROVE;
			best = '0;
		end
	end

	// Hold the result beat until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			posterior_fraud <= s3.err ? '0 : p3;
			action          <= act;
			expected_loss   <= best;
			error           <= s3.err;
		end
	end
endmodule

FILE: sv/sbfs_div_cell.sv
// Division cell: one restoring step of the quotient chain.
module sbfs_div_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  sbfs_pkg::div_t       in_div,
	input  sbfs_pkg::side_t      in_side,
	output logic                 out_valid,
	output sbfs_pkg::div_t       out_div,
	output sbfs_pkg::side_t      out_side
);
	logic [sbfs_pkg::DEN_W-1:0] diff;
	logic                       ge;
	sbfs_pkg::div_t             nxt;

	// Try one subtract, then shift the remainder for the next cell.
	always_comb begin
		ge      = (in_div.rem >= in_div.den);
		diff    = ge ? (in_div.rem - in_div.den) : in_div.rem;
		nxt.den = in_div.den;
		nxt.rem = {diff[sbfs_pkg::DEN_W-2:0], 1'b0};
		nxt.quo = {in_div.quo[sbfs_pkg::Q_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_div  <= nxt;
			out_side <= in_side;
		end
	end
endmodule

FILE: sv/sbfs_update.sv
// Bayes update: evidence terms, then a chain of division cells.
module sbfs_update (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  logic [sbfs_pkg::PROB_W-1:0]    in_p,
	input  logic                           flag,
	input  logic [sbfs_pkg::PROB_W-1:0]    pf,
	input  logic [sbfs_pkg::PROB_W-1:0]    pl,
	input  sbfs_pkg::side_t                in_side,
	output logic                           out_valid,
	output logic [sbfs_pkg::PROB_W-1:0]    out_p,
	output sbfs_pkg::side_t                out_side
);
	localparam int N = sbfs_pkg::NUM_CELLS;

	logic [sbfs_pkg::PROB_W-1:0] lf, ll;
	logic [sbfs_pkg::NUM_W-1:0]  num_c, alt_c;
	logic [sbfs_pkg::NUM_W-1:0]  num_s1, alt_s1;
	logic                        v_s1;
	sbfs_pkg::side_t             side_s1;
	logic [sbfs_pkg::DEN_W-1:0]  den;
	sbfs_pkg::div_t              d0;
	sbfs_pkg::side_t             s0;

	logic            cv [N+1];
	sbfs_pkg::div_t  cd [N+1];
	sbfs_pkg::side_t cs [N+1];

	// Form both likelihood products.
	always_comb begin
		lf    = flag ? pf : sbfs_pkg::ONE_Q - pf;
		ll    = flag ? pl : sbfs_pkg::ONE_Q - pl;
		num_c = sbfs_pkg::NUM_W'(lf) * sbfs_pkg::NUM_W'(in_p);
		alt_c = sbfs_pkg::NUM_W'(ll) * sbfs_pkg::NUM_W'(sbfs_pkg::ONE_Q - in_p);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1  <= num_c;
			alt_s1  <= alt_c;
			side_s1 <= in_side;
		end
	end

	// Seed the chain; zero evidence raises the error.
	always_comb begin
		den     = {1'b0, num_s1} + {1'b0, alt_s1};
		d0.den  = den;
		d0.rem  = {1'b0, num_s1};
		d0.quo  = '0;
		s0      = side_s1;
		if (den == '0) begin
			s0.err = 1'b1;
			d0.den = sbfs_pkg::DEN_W'(1);
			d0.rem = '0;
		end
		// Drop the work of an item that already failed.
		if (side_s1.err) begin
			d0.den = sbfs_pkg::DEN_W'(1);
			d0.rem = '0;
		end
	end

	assign cv[0] = v_s1;
	assign cd[0] = d0;
	assign cs[0] = s0;

	// The first cell yields the integer bit, the rest one fraction bit each.
	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_cell
			sbfs_div_cell u_cell (
				.clk(clk), .arst_n(arst_n), .en(en),
				.in_valid(cv[g]), .in_div(cd[g]), .in_side(cs[g]),
				.out_valid(cv[g+1]), .out_div(cd[g+1]), .out_side(cs[g+1])
			);
		end
	endgenerate

	assign out_valid = cv[N];
	assign out_p     = cs[N].err ? '0 : cd[N].quo;
	assign out_side  = cs[N];
endmodule

FILE: sv/sbfs_checker.sv
// Port checker for the fraud scorer, bound to the top level.
module sbfs_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [sbfs_pkg::PROB_W-1:0] posterior_fraud,
	input logic [1:0]                  action,
	input logic [sbfs_pkg::LOSS_W-1:0] expected_loss,
	input logic                        error
);
	// A stalled result beat holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(posterior_fraud))
		else $error("result beat changed while stalled");

	// Input is taken exactly when the output side is not blocked.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output stall");

	// An error result carries zero fields.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> posterior_fraud == '0 && expected_loss == '0
		&& action == sbfs_pkg::ACT_APPROVE)
		else $error("error beat has nonzero fields");

	// Posterior never exceeds one.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> posterior_fraud <= sbfs_pkg::ONE_Q)
		else $error("posterior above one");
endmodule

bind sequential_bayes_fraud_scorer_unit sbfs_checker u_sbfs_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready), .out_valid(out_valid),
	.out_ready(out_ready), .posterior_fraud(posterior_fraud), .action(action),
	.expected_loss(expected_loss), .error(error)
);

FILE: tb/sequential_bayes_fraud_scorer_unit_tb.sv
// Testbench for the sequential Bayes fraud scorer: directed and random beats vs a local predictor.
module sequential_bayes_fraud_scorer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [sbfs_pkg::PROB_W-1:0] post;
		logic [1:0]                  act;
		logic [sbfs_pkg::LOSS_W-1:0] loss;
		logic                        err;
	} score_t;

	// Scoreboard: holds the register copy and the queue of expected scores.
	class score_board;
		logic [sbfs_pkg::PROB_W-1:0]      regs [8];
		logic [sbfs_pkg::AMOUNT_BITS-1:0] thresh;
		score_t                           pending [$];
		int                               errors;

		function new();
			regs[0] = sbfs_pkg::PROB_W'(1311);
			regs[1] = '0;
			regs[2] = sbfs_pkg::PROB_W'(45875);
			regs[3] = sbfs_pkg::PROB_W'(6554);
			regs[4] = sbfs_pkg::PROB_W'(52429);
			regs[5] = sbfs_pkg::PROB_W'(3277);
			regs[6] = sbfs_pkg::PROB_W'(49152);
			regs[7] = sbfs_pkg::PROB_W'(5243);
			thresh = sbfs_pkg::AMOUNT_BITS'(5000);
			errors = 0;
		endfunction

		function void write_reg(logic [sbfs_pkg::IDX_W-1:0] idx,
				logic [sbfs_pkg::CFG_W-1:0] val);
			if (idx == sbfs_pkg::REG_THRESH)
				thresh = val;
			else
				regs[idx] = val[sbfs_pkg::PROB_W-1:0];
		endfunction

		function logic [sbfs_pkg::PROB_W-1:0] clamp(logic [sbfs_pkg::PROB_W-1:0] v);
			return (v > sbfs_pkg::ONE_Q) ? sbfs_pkg::ONE_Q : v;
		endfunction

		// One binary update; returns 0 on zero evidence.
		function bit update(inout logic [63:0] p, input bit flag,
				input logic [sbfs_pkg::PROB_W-1:0] pf,
				input logic [sbfs_pkg::PROB_W-1:0] pl);
			logic [63:0] lf, ll, num, den;
			lf = flag ? 64'(clamp(pf)) : 64'(sbfs_pkg::ONE_Q - clamp(pf));
			ll = flag ? 64'(clamp(pl)) : 64'(sbfs_pkg::ONE_Q - clamp(pl));
			num = lf * p;
			den = num + ll * (64'(sbfs_pkg::ONE_Q) - p);
			if (den == 0)
				return 0;
			p = (num << sbfs_pkg::FRAC_BITS) / den;
			return 1;
		endfunction

		function void note_txn(logic [sbfs_pkg::AMOUNT_BITS-1:0] amt, bit loc, bit dev);
			logic [63:0] p, lg, la, ld, lr;
			score_t s;
			bit ok;
			p = 64'(clamp(regs[0]));
			ok = update(p, amt >= thresh, regs[2], regs[3]);
			if (ok) ok = update(p, loc, regs[4], regs[5]);
			if (ok) ok = update(p, dev, regs[6], regs[7]);
			if (!ok) begin
				s = '{post: '0, act: sbfs_pkg::ACT_APPROVE, loss: '0, err: 1'b1};
			end else begin
				lg = 64'(sbfs_pkg::ONE_Q) - p;
				la = 64'(100) * p;
				ld = 64'(20) * lg;
				lr = 64'(10) * p + 64'(2) * lg;
				s = '{post: sbfs_pkg::PROB_W'(p), act: sbfs_pkg::ACT_APPROVE,
					loss: sbfs_pkg::LOSS_W'(la), err: 1'b0};
				if (ld < 64'(s.loss)) begin
					s.act = sbfs_pkg::ACT_DECLINE;
					s.loss = sbfs_pkg::LOSS_W'(ld);
				end
				if (lr < 64'(s.loss)) begin
					s.act = sbfs_pkg::ACT_REVIEW;
					s.loss = sbfs_pkg::LOSS_W'(lr);
				end
			end
			pending.insert(pending.size(), s);
		endfunction

		function void check_score(score_t got);
			score_t w;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result post=%0d", $realtime, got.post);
				errors++;
				return;
			end
			w = pending.pop_front();
			if (got.post !== w.post) begin
				$display("%0t: posterior exp %0d got %0d", $realtime, w.post, got.post);
				errors++;
			end
			if (got.act !== w.act) begin
				$display("%0t: action exp %0d got %0d", $realtime, w.act, got.act);
				errors++;
			end
			if (got.loss !== w.loss) begin
				$display("%0t: loss exp %0d got %0d", $realtime, w.loss, got.loss);
				errors++;
			end
			if (got.err !== w.err) begin
				$display("%0t: error exp %0d got %0d", $realtime, w.err, got.err);
				errors++;
			end
		endfunction
	endclass

	logic                             clk = 0, arst_n = 0;
	logic                             in_valid = 0, in_ready, out_valid, out_ready = 0;
	logic [sbfs_pkg::AMOUNT_BITS-1:0] amount = 0;
	logic                             unusual_location = 0, unusual_device = 0;
	logic [sbfs_pkg::PROB_W-1:0]      posterior_fraud;
	logic [1:0]                       action;
	logic [sbfs_pkg::LOSS_W-1:0]      expected_loss;
	logic                             error;
	logic                             cfg_we = 0;
	logic [sbfs_pkg::IDX_W-1:0]       cfg_index = 0;
	logic [sbfs_pkg::CFG_W-1:0]       cfg_data = 0;

	score_board sb = new();
	bit         calm = 0;
	longint     cycles = 0;

	sequential_bayes_fraud_scorer_unit DUT (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	// Abort on a runaway run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("sequential_bayes_fraud_scorer_unit_tb: errors");
			$finish;
		end
	end

	// Check each output beat and stall the receiver in bursts.
	initial begin
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_score('{post: posterior_fraud, act: action,
					loss: expected_loss, err: error});
			if (hold > 0) begin
				hold--;
				out_ready <= 0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				hold = $urandom_range(1, 10);
				out_ready <= 0;
			end else
				out_ready <= 1;
		end
	end

	// Write one register; the next beat sent drops the write enable.
	task automatic write_cfg(logic [sbfs_pkg::IDX_W-1:0] idx,
			logic [sbfs_pkg::CFG_W-1:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		sb.write_reg(idx, val);
		@(posedge clk);
	endtask

	// Drive one beat, with an optional random gap before it.
	task automatic send_txn(logic [sbfs_pkg::AMOUNT_BITS-1:0] amt, bit loc, bit dev);
		cfg_we <= 0;
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1;
		amount <= amt;
		unusual_location <= loc;
		unusual_device <= dev;
		do @(posedge clk); while (!in_ready);
		sb.note_txn(amt, loc, dev);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic logic [sbfs_pkg::CFG_W-1:0] rand_prob();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return sbfs_pkg::CFG_W'(sbfs_pkg::ONE_Q);
			2: return sbfs_pkg::CFG_W'($urandom_range(sbfs_pkg::ONE_Q + 1, 24'hffffff));
			3: return sbfs_pkg::CFG_W'($urandom_range(0, 16));
			4: return sbfs_pkg::CFG_W'(sbfs_pkg::ONE_Q - $urandom_range(0, 16));
			default: return sbfs_pkg::CFG_W'($urandom_range(0, sbfs_pkg::ONE_Q));
		endcase
	endfunction

	function automatic logic [sbfs_pkg::AMOUNT_BITS-1:0] rand_amount(
			logic [sbfs_pkg::AMOUNT_BITS-1:0] th);
		case ($urandom_range(0, 5))
			0: return th;
			1: return th - 1'b1;
			2: return 24'hffffff;
			3: return '0;
			default: return sbfs_pkg::AMOUNT_BITS'($urandom());
		endcase
	endfunction

	initial begin
		int k;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Directed: reset settings, field extremes, threshold edges.
		send_txn(0, 0, 0);
		send_txn(24'hffffff, 1, 1);
		send_txn(4999, 1, 0);
		send_txn(5000, 0, 1);
		send_txn(5001, 1, 1);
		drain();
		// Saturation and zero-evidence settings.
		write_cfg(sbfs_pkg::REG_PRIOR, 24'hffffff);
		write_cfg(sbfs_pkg::REG_THRESH, '0);
		write_cfg(sbfs_pkg::REG_AMT_F, '0);
		write_cfg(sbfs_pkg::REG_AMT_L, '0);
		send_txn(7, 0, 0);
		send_txn(7, 1, 1);
		drain();
		write_cfg(sbfs_pkg::REG_PRIOR, '0);
		write_cfg(sbfs_pkg::REG_AMT_F, sbfs_pkg::CFG_W'(sbfs_pkg::ONE_Q));
		write_cfg(sbfs_pkg::REG_AMT_L, sbfs_pkg::CFG_W'(sbfs_pkg::ONE_Q));
		write_cfg(sbfs_pkg::REG_LOC_F, sbfs_pkg::CFG_W'(sbfs_pkg::ONE_Q));
		write_cfg(sbfs_pkg::REG_LOC_L, 24'h1ffff);
		write_cfg(sbfs_pkg::REG_DEV_F, '0);
		write_cfg(sbfs_pkg::REG_DEV_L, sbfs_pkg::CFG_W'(sbfs_pkg::ONE_Q));
		send_txn(1, 0, 0);
		send_txn(1, 1, 0);
		send_txn(1, 1, 1);
		drain();
		write_cfg(sbfs_pkg::REG_PRIOR, sbfs_pkg::CFG_W'(sbfs_pkg::ONE_Q));
		write_cfg(sbfs_pkg::REG_THRESH, 24'hffffff);
		send_txn(24'hfffffe, 1, 0);
		send_txn(24'hffffff, 1, 1);
		drain();
		write_cfg(sbfs_pkg::REG_PRIOR, sbfs_pkg::CFG_W'(sbfs_pkg::ONE_Q / 2));
		write_cfg(sbfs_pkg::REG_AMT_F, sbfs_pkg::CFG_W'(sbfs_pkg::ONE_Q / 2));
		write_cfg(sbfs_pkg::REG_LOC_F, sbfs_pkg::CFG_W'(sbfs_pkg::ONE_Q / 2));
		write_cfg(sbfs_pkg::REG_LOC_L, sbfs_pkg::CFG_W'(sbfs_pkg::ONE_Q / 2));
		write_cfg(sbfs_pkg::REG_DEV_F, sbfs_pkg::CFG_W'(sbfs_pkg::ONE_Q / 2));
		write_cfg(sbfs_pkg::REG_DEV_L, sbfs_pkg::CFG_W'(sbfs_pkg::ONE_Q / 2));
		send_txn(0, 1, 1);
		send_txn(24'hffffff, 0, 0);
		drain();
		// Random phases, each with fresh settings; the sender waits out each one.
		for (int ph = 0; ph < 10; ph++) begin
			for (int r = 0; r < 8; r++)
				write_cfg(sbfs_pkg::IDX_W'(r), (r == sbfs_pkg::REG_THRESH) ?
					((ph % 3 == 0) ? sbfs_pkg::CFG_W'($urandom()) :
					sbfs_pkg::CFG_W'($urandom_range(0, 4096))) : rand_prob());
			if (ph == 9) calm = 1;
			for (k = 0; k < 100; k++)
				send_txn(rand_amount(sb.thresh), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
			drain();
		end
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("sequential_bayes_fraud_scorer_unit_tb: clean");
		else
			$display("sequential_bayes_fraud_scorer_unit_tb: errors");
		$finish;
	end
endmodule

FILE: sequential_bayes_fraud_scorer_unit.f
sv/sbfs_pkg.sv
sv/sbfs_div_cell.sv
sv/sbfs_update.sv
sv/sequential_bayes_fraud_scorer_unit.sv
sv/sbfs_checker.sv
tb/sequential_bayes_fraud_scorer_unit_tb.sv
